>>> hw/rtl/ott_pkg.sv
// Shared types and constants for the ordered timer table.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package ott_pkg;

  localparam int unsigned TIME_W         = 64;
  localparam int unsigned SLOT_W         = 4;
  localparam int unsigned OP_W           = 3;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned NUM_TIMERS_DEF = 16;
  // most beats a single collect may return
  localparam int unsigned RESULT_CAP     = 16;
  localparam int unsigned CAP_W          = $clog2(RESULT_CAP + 1);
  localparam int unsigned ORD_IW         = $clog2(RESULT_CAP);

  localparam logic [TIME_W-1:0] TIME_ALL_ONES = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 3'd0,
    OP_CANCEL  = 3'd1,
    OP_RESET   = 3'd2,
    OP_REFRESH = 3'd3,
    OP_COLLECT = 3'd4,
    OP_NEXT    = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_NONE_DUE  = 2'd3
  } status_e;

  // slot flag updates, at most one per cycle
  typedef struct packed {
    logic alloc;
    logic cancel;
    logic expire;
    logic mark_per;
  } flag_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/ott_if.sv
// Request and response channels of the ordered timer table.
// Depends on ott_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ott_req_if;
  logic                          valid;
  logic                          ready;
  logic [ott_pkg::OP_W-1:0]      opcode;
  logic [ott_pkg::SLOT_W-1:0]    slot;
  logic [ott_pkg::TIME_W-1:0]    period;
  logic                          recur;
  logic                          restart_now;
  logic [ott_pkg::TIME_W-1:0]    now_time;

  modport source (output valid, opcode, slot, period, recur, restart_now, now_time,
                  input ready);
  modport sink   (input valid, opcode, slot, period, recur, restart_now, now_time,
                  output ready);
endinterface

interface ott_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ott_pkg::STATUS_W-1:0]  status;
  logic [ott_pkg::SLOT_W-1:0]    result_slot;
  logic [ott_pkg::TIME_W-1:0]    next_delay;
  logic                          front_notice;
  logic                          any_pending;
  logic                          last;

  modport source (output valid, status, result_slot, next_delay, front_notice,
                  any_pending, last, input ready);
  modport sink   (input valid, status, result_slot, next_delay, front_notice,
                  any_pending, last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ott_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ott_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hw/rtl/ott_flags.sv
// Per-slot flag bits (pending, armed, recurring, period written) and the
// free-slot encoder. Depends on ott_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ott_flags #(
  parameter int unsigned NUM_TIMERS = ott_pkg::NUM_TIMERS_DEF,
  localparam int unsigned IW        = $clog2(NUM_TIMERS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ott_pkg::flag_cmd_t    cmd_i,
  input  logic [IW-1:0]         idx_i,
  input  logic                  rec_i,
  output logic [NUM_TIMERS-1:0] pending_o,
  output logic [NUM_TIMERS-1:0] armed_o,
  output logic [NUM_TIMERS-1:0] recur_o,
  output logic [NUM_TIMERS-1:0] per_vld_o,
  output logic                  full_o,
  output logic                  any_o,
  output logic [IW-1:0]         free_idx_o
);

  import ott_pkg::*;

  logic [NUM_TIMERS-1:0] pend_q, arm_q, rec_q, pvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      arm_q  <= '0;
      rec_q  <= '0;
      pvld_q <= '0;
    end else begin
      if (cmd_i.alloc) begin
        pend_q[idx_i] <= 1'b1;
        arm_q[idx_i]  <= 1'b1;
        rec_q[idx_i]  <= rec_i;
        pvld_q[idx_i] <= 1'b1;
      end
      if (cmd_i.cancel) begin
        pend_q[idx_i] <= 1'b0;
      end
      if (cmd_i.expire) begin
        pend_q[idx_i] <= 1'b0;
        arm_q[idx_i]  <= 1'b0;
      end
      if (cmd_i.mark_per) begin
        pvld_q[idx_i] <= 1'b1;
      end
    end
  end

  // lowest free slot wins
  always_comb begin
    free_idx_o = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!pend_q[i]) free_idx_o = IW'(i);
    end
  end

  assign pending_o = pend_q;
  assign armed_o   = arm_q;
  assign recur_o   = rec_q;
  assign per_vld_o = pvld_q;
  assign full_o    = &pend_q;
  assign any_o     = |pend_q;

endmodule

`default_nettype wire

>>> hw/rtl/ordered_timer_table_core.sv
// Ordered timer table: NUM_TIMERS slots whose periods and expiry times sit in
// two one-port-read RAMs, flags in flops. One request is worked at a time; the
// output register lets the next request in while a beat waits. Cancel and
// unknown opcodes go straight to the response. Add, reset, refresh and next
// walk the expiry RAM once, one slot per cycle, unless they fail or change
// nothing early. Collect with m due timers runs m + 1 such walks (m once 16
// are found), with a recur write-back step after each recurring timer, to
// pull them out in expiry order, then sends m beats, or one nothing-due beat
// if m is 0. At most 16 timers come out per collect. No clearing pass after reset.
// Depends on ott_pkg, ott_if, ott_ram, ott_flags.
`timescale 1ns / 1ps
`default_nettype none

module ordered_timer_table_core #(
  parameter int unsigned NUM_TIMERS = ott_pkg::NUM_TIMERS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ott_req_if.sink   req_i,
  ott_rsp_if.source rsp_o
);

  import ott_pkg::*;

  localparam int unsigned IW = $clog2(NUM_TIMERS);
  localparam int unsigned CW = $clog2(NUM_TIMERS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_KEEP, S_SCAN, S_PASS, S_RECUR, S_RESP, S_EMIT
  } state_e;

  state_e              state_q;
  op_e                 op_q;
  logic                slot_ok_q, rec_q, fromnow_q;
  logic [IW-1:0]       tgt_q, rd_addr_q;
  logic [TIME_W-1:0]   per_q, now_q, e_q;
  logic [CW-1:0]       cnt_q;
  logic                best_vld_q, blocked_q, notice_q;
  logic [IW-1:0]       best_idx_q;
  logic [TIME_W-1:0]   best_exp_q;
  logic [CAP_W-1:0]    n_q, k_q;
  logic [IW-1:0]       ord_q [RESULT_CAP];
  logic [NUM_TIMERS-1:0] done_q;
  status_e             res_status_q;
  logic [SLOT_W-1:0]   res_slot_q;
  logic [TIME_W-1:0]   res_dly_q;
  logic                res_fn_q;

  logic                ov_q, o_fn_q, o_any_q, o_last_q;
  status_e             o_status_q;
  logic [SLOT_W-1:0]   o_slot_q;
  logic [TIME_W-1:0]   o_dly_q;

  // flags
  flag_cmd_t             flag_cmd;
  logic [IW-1:0]         flag_idx;
  logic [NUM_TIMERS-1:0] pending, armed, recur, per_vld;
  logic                  full, any_pend;
  logic [IW-1:0]         free_idx;

  // RAM ports
  logic                per_we, exp_we;
  logic [IW-1:0]       per_waddr, exp_waddr, rd_addr;
  logic [TIME_W-1:0]   exp_wdata, per_rd, exp_rd, per_val;

  ott_flags #(.NUM_TIMERS(NUM_TIMERS)) u_flags (
    .clk_i, .rst_ni,
    .cmd_i(flag_cmd), .idx_i(flag_idx), .rec_i(rec_q),
    .pending_o(pending), .armed_o(armed), .recur_o(recur), .per_vld_o(per_vld),
    .full_o(full), .any_o(any_pend), .free_idx_o(free_idx)
  );

  ott_ram #(.DEPTH(NUM_TIMERS), .WIDTH(TIME_W)) u_per_ram (
    .clk_i, .we_i(per_we), .waddr_i(per_waddr), .wdata_i(per_q),
    .raddr_i(rd_addr), .rdata_o(per_rd)
  );

  ott_ram #(.DEPTH(NUM_TIMERS), .WIDTH(TIME_W)) u_exp_ram (
    .clk_i, .we_i(exp_we), .waddr_i(exp_waddr), .wdata_i(exp_wdata),
    .raddr_i(rd_addr), .rdata_o(exp_rd)
  );

  // a period never written reads as zero
  assign per_val = per_vld[rd_addr_q] ? per_rd : '0;

  logic usable, unchanged, cancel_hit;
  assign cancel_hit = slot_ok_q && pending[tgt_q];
  assign usable     = slot_ok_q && pending[tgt_q] && armed[tgt_q];
  assign unchanged  = (op_q == OP_RESET) && (per_q == per_val) && !fromnow_q;

  // scan compare on the slot read last cycle
  logic [IW-1:0] p;
  logic          ins_block, cand, better, out_free, o_load;
  assign p         = IW'(cnt_q - CW'(1));
  assign ins_block = pending[p] && (p != tgt_q) &&
                     ((exp_rd < e_q) || ((exp_rd == e_q) && (p < tgt_q)));
  assign cand      = pending[p] &&
                     ((op_q != OP_COLLECT) || (!done_q[p] && (exp_rd <= now_q)));
  assign better    = cand && (!best_vld_q || (exp_rd < best_exp_q));
  assign out_free  = !ov_q || rsp_o.ready;
  assign o_load    = out_free && ((state_q == S_RESP) || (state_q == S_EMIT));

  always_comb begin
    flag_cmd  = '0;
    flag_idx  = tgt_q;
    per_we    = 1'b0;
    per_waddr = tgt_q;
    exp_we    = 1'b0;
    exp_waddr = tgt_q;
    exp_wdata = now_q + per_val;
    rd_addr   = tgt_q;
    case (state_q)
      S_IDLE: rd_addr = IW'(req_i.slot);
      S_EXEC: begin
        case (op_q)
          OP_ADD: begin
            if (!full) begin
              flag_cmd.alloc = 1'b1;
              flag_idx       = free_idx;
              per_we         = 1'b1;
              per_waddr      = free_idx;
              exp_we         = 1'b1;
              exp_waddr      = free_idx;
              exp_wdata      = now_q + per_q;
            end
          end
          OP_CANCEL: flag_cmd.cancel = cancel_hit;
          OP_RESET: begin
            if (slot_ok_q && !unchanged && usable) begin
              per_we            = 1'b1;
              flag_cmd.mark_per = 1'b1;
              exp_we            = fromnow_q;
              exp_wdata         = now_q + per_q;
            end
          end
          OP_REFRESH: exp_we = usable;
          default: ;
        endcase
      end
      S_KEEP: begin
        exp_we    = 1'b1;
        exp_wdata = e_q + per_q;
      end
      S_SCAN: rd_addr = cnt_q[IW-1:0];
      S_PASS: begin
        if (op_q == OP_COLLECT && best_vld_q) begin
          rd_addr         = best_idx_q;
          flag_idx        = best_idx_q;
          flag_cmd.expire = !recur[best_idx_q];
        end
      end
      S_RECUR: begin
        exp_we    = 1'b1;
        exp_waddr = best_idx_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_ADD;
      slot_ok_q    <= 1'b0;
      rec_q        <= 1'b0;
      fromnow_q    <= 1'b0;
      tgt_q        <= '0;
      rd_addr_q    <= '0;
      per_q        <= '0;
      now_q        <= '0;
      e_q          <= '0;
      cnt_q        <= '0;
      best_vld_q   <= 1'b0;
      blocked_q    <= 1'b0;
      notice_q     <= 1'b0;
      best_idx_q   <= '0;
      best_exp_q   <= '0;
      n_q          <= '0;
      k_q          <= '0;
      ord_q        <= '{default: '0};
      done_q       <= '0;
      res_status_q <= ST_OK;
      res_slot_q   <= '0;
      res_dly_q    <= '0;
      res_fn_q     <= 1'b0;
      ov_q         <= 1'b0;
      o_status_q   <= ST_OK;
      o_slot_q     <= '0;
      o_dly_q      <= '0;
      o_fn_q       <= 1'b0;
      o_any_q      <= 1'b0;
      o_last_q     <= 1'b0;
    end else begin
      rd_addr_q <= rd_addr;
      if (o_load) ov_q <= 1'b1;
      else if (rsp_o.ready) ov_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            op_q       <= op_e'(req_i.opcode);
            slot_ok_q  <= (32'(req_i.slot) < NUM_TIMERS);
            tgt_q      <= IW'(req_i.slot);
            per_q      <= req_i.period;
            now_q      <= req_i.now_time;
            rec_q      <= req_i.recur;
            fromnow_q  <= req_i.restart_now;
            res_slot_q <= '0;
            res_dly_q  <= '0;
            res_fn_q   <= 1'b0;
            cnt_q      <= '0;
            best_vld_q <= 1'b0;
            blocked_q  <= 1'b0;
            state_q    <= S_EXEC;
          end
        end

        S_EXEC: begin
          case (op_q)
            OP_ADD: begin
              if (full) begin
                res_status_q <= ST_FULL;
                state_q      <= S_RESP;
              end else begin
                tgt_q   <= free_idx;
                e_q     <= now_q + per_q;
                state_q <= S_SCAN;
              end
            end
            OP_CANCEL: begin
              res_status_q <= cancel_hit ? ST_OK : ST_NOT_FOUND;
              state_q      <= S_RESP;
            end
            OP_RESET, OP_REFRESH: begin
              if (!slot_ok_q) begin
                res_status_q <= ST_NOT_FOUND;
                state_q      <= S_RESP;
              end else if (unchanged) begin
                res_status_q <= ST_OK;
                state_q      <= S_RESP;
              end else if (!usable) begin
                res_status_q <= ST_NOT_FOUND;
                state_q      <= S_RESP;
              end else if (op_q == OP_RESET && !fromnow_q) begin
                // keep the original start: old expiry minus old period
                e_q     <= exp_rd - per_val;
                state_q <= S_KEEP;
              end else begin
                e_q     <= now_q + ((op_q == OP_RESET) ? per_q : per_val);
                state_q <= S_SCAN;
              end
            end
            OP_COLLECT: begin
              n_q     <= '0;
              done_q  <= '0;
              state_q <= S_SCAN;
            end
            OP_NEXT: begin
              notice_q <= 1'b0;
              state_q  <= S_SCAN;
            end
            default: begin
              res_status_q <= ST_NOT_FOUND;
              state_q      <= S_RESP;
            end
          endcase
        end

        S_KEEP: begin
          e_q     <= e_q + per_q;
          state_q <= S_SCAN;
        end

        S_SCAN: begin
          if (cnt_q != '0) begin
            if (ins_block) blocked_q <= 1'b1;
            if (better) begin
              best_vld_q <= 1'b1;
              best_idx_q <= p;
              best_exp_q <= exp_rd;
            end
          end
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(NUM_TIMERS)) state_q <= S_PASS;
        end

        S_PASS: begin
          cnt_q      <= '0;
          best_vld_q <= 1'b0;
          case (op_q)
            OP_COLLECT: begin
              if (!best_vld_q) begin
                k_q <= '0;
                if (n_q == '0) begin
                  res_status_q <= ST_NONE_DUE;
                  state_q      <= S_RESP;
                end else begin
                  state_q <= S_EMIT;
                end
              end else begin
                ord_q[n_q[ORD_IW-1:0]] <= best_idx_q;
                done_q[best_idx_q]     <= 1'b1;
                n_q                    <= n_q + CAP_W'(1);
                k_q                    <= '0;
                if (recur[best_idx_q]) begin
                  state_q <= S_RECUR;
                end else if (n_q == CAP_W'(RESULT_CAP - 1)) begin
                  state_q <= S_EMIT;
                end else begin
                  state_q <= S_SCAN;
                end
              end
            end
            OP_NEXT: begin
              res_status_q <= ST_OK;
              if (!best_vld_q) begin
                res_dly_q <= TIME_ALL_ONES;
              end else if (best_exp_q <= now_q) begin
                res_dly_q <= '0;
              end else begin
                res_dly_q <= best_exp_q - now_q;
              end
              state_q <= S_RESP;
            end
            default: begin
              // add/reset/refresh: notice if none pending ahead, none since next
              res_status_q <= ST_OK;
              res_slot_q   <= (op_q == OP_ADD) ? SLOT_W'(tgt_q) : '0;
              res_fn_q     <= !blocked_q && !notice_q;
              if (!blocked_q) notice_q <= 1'b1;
              state_q <= S_RESP;
            end
          endcase
        end

        S_RECUR: begin
          state_q <= (n_q == CAP_W'(RESULT_CAP)) ? S_EMIT : S_SCAN;
        end

        S_RESP: begin
          if (out_free) begin
            o_status_q <= res_status_q;
            o_slot_q   <= res_slot_q;
            o_dly_q    <= res_dly_q;
            o_fn_q     <= res_fn_q;
            o_any_q    <= any_pend;
            o_last_q   <= 1'b1;
            state_q    <= S_IDLE;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            o_status_q <= ST_OK;
            o_slot_q   <= SLOT_W'(ord_q[k_q[ORD_IW-1:0]]);
            o_dly_q    <= '0;
            o_fn_q     <= 1'b0;
            o_any_q    <= any_pend;
            o_last_q   <= (k_q + CAP_W'(1) == n_q);
            k_q        <= k_q + CAP_W'(1);
            if (k_q + CAP_W'(1) == n_q) state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = ov_q;
  assign rsp_o.status       = o_status_q;
  assign rsp_o.result_slot  = o_slot_q;
  assign rsp_o.next_delay   = o_dly_q;
  assign rsp_o.front_notice = o_fn_q;
  assign rsp_o.any_pending  = o_any_q;
  assign rsp_o.last         = o_last_q;

endmodule

`default_nettype wire

>>> hw/rtl/ott_checker.sv
// Port-level checks on the response channel of ordered_timer_table_core,
// with the bind that attaches them. Depends on ott_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ott_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [ott_pkg::STATUS_W-1:0]  status_i,
  input logic [ott_pkg::SLOT_W-1:0]    slot_i,
  input logic [ott_pkg::TIME_W-1:0]    delay_i,
  input logic                          notice_i,
  input logic                          any_i,
  input logic                          last_i
);

  import ott_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i &&
      $stable({status_i, slot_i, delay_i, notice_i, any_i, last_i}))
    else $error("response beat changed while stalled");

  a_none_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_NONE_DUE) |-> last_i && (slot_i == '0))
    else $error("nothing-due beat must be a lone beat");

  a_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (delay_i != '0) |-> (status_i == ST_OK) && last_i && !notice_i)
    else $error("delay on a beat that is not a next-delay answer");

  a_notice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && notice_i |-> (status_i == ST_OK) && last_i)
    else $error("front notice on a failed or multi-beat answer");

endmodule

bind ordered_timer_table_core ott_checker u_ott_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .status_i    (rsp_o.status),
  .slot_i      (rsp_o.result_slot),
  .delay_i     (rsp_o.next_delay),
  .notice_i    (rsp_o.front_notice),
  .any_i       (rsp_o.any_pending),
  .last_i      (rsp_o.last)
);

`default_nettype wire
